>>> hdl/rhp_pkg.sv
// Shared types and constants for the RTP fixed-header parser.
package rhp_pkg;

    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] FIXED_HEADER_LEN = 7'd12;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_SHORT_FIXED = 2'd0;
    localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
    localparam logic [1:0] ERR_SHORT_CSRC = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_res;
        logic [31:0] stamp;
        logic [31:0] source_id;
        logic [3:0]  csrc_count;
        logic [7:0]  payload_data;
        logic [1:0]  error_code;
        logic        packet_end;
    } rhp_result_t;

endpackage

>>> hdl/rhp_parser.sv
// Byte-position tracking, header gathering and result generation for one packet byte.
module rhp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 push,
    output rhp_pkg::rhp_result_t result
);
    import rhp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       second_reg, second_next;
    logic [15:0]      seq_reg, seq_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [31:0]      source_reg, source_next;
    logic             done_reg, done_next;
    logic             drop_reg, drop_next;
    logic             has_result;
    logic [POS_W-1:0] count;
    logic [3:0]       cc;
    logic [POS_W-1:0] hdr_len;
    logic             clear;

    assign count = pos_reg + 7'd1;
    assign cc = first_reg[3:0];
    assign hdr_len = FIXED_HEADER_LEN + {1'b0, cc, 2'b00};

    always_comb
    begin
        pos_next = pos_reg;
        first_next = first_reg;
        second_next = second_reg;
        seq_next = seq_reg;
        stamp_next = stamp_reg;
        source_next = source_reg;
        done_next = done_reg;
        drop_next = drop_reg;
        has_result = 1'b0;
        clear = 1'b0;
        result = '0;

        if (!drop_reg && !done_reg)
        begin
            if (pos_reg == 7'd0)
            begin
                first_next = data_byte;
            end
            else if (pos_reg == 7'd1)
            begin
                second_next = data_byte;
            end
            else if (pos_reg < 7'd4)
            begin
                seq_next = {seq_reg[7:0], data_byte};
            end
            else if (pos_reg < 7'd8)
            begin
                stamp_next = {stamp_reg[23:0], data_byte};
            end
            else if (pos_reg < FIXED_HEADER_LEN)
            begin
                source_next = {source_reg[23:0], data_byte};
            end
        end

        if (drop_reg)
        begin
            clear = last_byte;
        end
        else if (done_reg)
        begin
            has_result = 1'b1;
            result.kind = KIND_PAYLOAD;
            result.payload_data = data_byte;
            result.packet_end = last_byte;
            clear = last_byte;
        end
        else if (count < FIXED_HEADER_LEN)
        begin
            if (last_byte)
            begin
                has_result = 1'b1;
                result.kind = KIND_ERROR;
                result.error_code = ERR_SHORT_FIXED;
                result.packet_end = 1'b1;
                clear = 1'b1;
            end
            else
            begin
                pos_next = count;
            end
        end
        else if (count == FIXED_HEADER_LEN && first_next[7:6] != RTP_VERSION)
        begin
            has_result = 1'b1;
            result.kind = KIND_ERROR;
            result.error_code = ERR_BAD_VERSION;
            result.packet_end = last_byte;
            clear = last_byte;
            drop_next = !last_byte;
        end
        else if (count >= hdr_len)
        begin
            has_result = 1'b1;
            result.kind = KIND_HEADER;
            result.marker = second_next[7];
            result.payload_type = second_next[6:0];
            result.sequence_res = seq_next;
            result.stamp = stamp_next;
            result.source_id = source_next;
            result.csrc_count = cc;
            result.packet_end = last_byte;
            clear = last_byte;
            done_next = !last_byte;
        end
        else if (last_byte)
        begin
            has_result = 1'b1;
            result.kind = KIND_ERROR;
            result.error_code = ERR_SHORT_CSRC;
            result.packet_end = 1'b1;
            clear = 1'b1;
        end
        else
        begin
            pos_next = count;
        end

        if (clear)
        begin
            pos_next = '0;
            first_next = '0;
            second_next = '0;
            seq_next = '0;
            stamp_next = '0;
            source_next = '0;
            done_next = 1'b0;
            drop_next = 1'b0;
        end
    end

    assign push = accept && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            first_reg <= '0;
            second_reg <= '0;
            seq_reg <= '0;
            stamp_reg <= '0;
            source_reg <= '0;
            done_reg <= 1'b0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            first_reg <= first_next;
            second_reg <= second_next;
            seq_reg <= seq_next;
            stamp_reg <= stamp_next;
            source_reg <= source_next;
            done_reg <= done_next;
            drop_reg <= drop_next;
        end
    end

    // The payload and drop phases exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n) !(done_reg && drop_reg))
        else $error("parser in payload and drop phase at once");

    // While gathering, the byte position never passes the longest header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!done_reg && !drop_reg) |-> (pos_reg < 7'd72))
        else $error("byte position beyond longest header");

    // A last byte always returns the parser to the start of a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (pos_reg == 7'd0 && !done_reg && !drop_reg))
        else $error("packet state not cleared after last byte");

endmodule

>>> hdl/rhp_skid.sv
// Output register with a skid stage, so that input is taken while a result waits.
module rhp_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rhp_pkg::rhp_result_t push_data,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rhp_pkg::rhp_result_t out_data
);
    import rhp_pkg::*;

    logic        out_valid_reg, out_valid_next;
    rhp_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    rhp_result_t skid_data_reg, skid_data_next;

    assign room = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next = skid_valid_reg || push;
            out_data_next = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid stage only holds a result behind a waiting output result.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register is empty");

    // No result is pushed while the skid stage is full.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> !push)
        else $error("result pushed into a full skid stage");

    // A result pushed during a stall lands in the skid stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && push) |=> skid_valid_reg)
        else $error("result lost during output stall");

endmodule

>>> hdl/rtp_header_parser_top.sv
// Top level of the RTP fixed-header parser.
//
// The input channel takes one packet byte per transfer on in_valid and
// in_ready, with last_byte set on the final byte of each packet.
// The output channel gives at most one result per input transfer on
// out_valid and out_ready: a header summary once the fixed header and the
// CSRC words have arrived, then one result per payload byte, or a single
// error result after which the rest of the packet is dropped.
// Each result is registered: in the result register, or in the skid stage
// while the output stalls. Unless in_ready is low, the block takes one byte
// in every cycle; the parse logic sits between the input ports and a result
// register backed by a one-entry skid stage. When the receiver stalls, one
// more result fits in the skid stage and in_ready falls only once that
// stage is full, returning as soon as the output drains. While the skid stage
// is full, in_ready stays low even for bytes that would give no result.
// Reset clears the packet state, so the next byte starts a new packet,
// and empties both result registers.
module rtp_header_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        marker,
    output logic [6:0]  payload_type,
    output logic [15:0] sequence_res,
    output logic [31:0] stamp,
    output logic [31:0] source_id,
    output logic [3:0]  csrc_count,
    output logic [7:0]  payload_data,
    output logic [1:0]  error_code,
    output logic        packet_end
);
    import rhp_pkg::*;

    logic        accept;
    logic        push;
    logic        room;
    rhp_result_t parse_result;
    rhp_result_t out_data;

    assign in_ready = room;
    assign accept = in_valid && room;

    rhp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .result    (parse_result)
    );

    rhp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (parse_result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind = out_data.kind;
    assign marker = out_data.marker;
    assign payload_type = out_data.payload_type;
    assign sequence_res = out_data.sequence_res;
    assign stamp = out_data.stamp;
    assign source_id = out_data.source_id;
    assign csrc_count = out_data.csrc_count;
    assign payload_data = out_data.payload_data;
    assign error_code = out_data.error_code;
    assign packet_end = out_data.packet_end;

endmodule

>>> tb/rtp_header_parser_top_tb.sv
// Self-checking testbench for the RTP fixed-header parser, with a scoreboard that predicts results.
`timescale 1ns / 1ps

module rtp_header_parser_top_tb;
    import rhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES = 1150;

    class rtp_result_board;
        logic [POS_W-1:0] header_pos;
        logic [7:0]       vcc_byte;
        logic [7:0]       mpt_byte;
        logic [15:0]      seq_acc;
        logic [31:0]      stamp_acc;
        logic [31:0]      ssrc_acc;
        logic             in_payload;
        logic             dropping;
        rhp_result_t      awaited_results[$];
        int               mismatches;
        int               parsed_bytes;

        function new();
            mismatches = 0;
            parsed_bytes = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            header_pos = '0;
            vcc_byte = '0;
            mpt_byte = '0;
            seq_acc = '0;
            stamp_acc = '0;
            ssrc_acc = '0;
            in_payload = 1'b0;
            dropping = 1'b0;
        endfunction

        function void queue_result(rhp_result_t r);
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            rhp_result_t      r;
            logic [POS_W-1:0] count;
            logic [POS_W-1:0] hdr_len;
            r = '0;
            parsed_bytes++;
            if (dropping)
            begin
                if (last)
                    clear_packet();
                return;
            end
            if (in_payload)
            begin
                r.kind = KIND_PAYLOAD;
                r.payload_data = b;
                r.packet_end = last;
                queue_result(r);
                if (last)
                    clear_packet();
                return;
            end
            if (header_pos == 0)
                vcc_byte = b;
            else if (header_pos == 1)
                mpt_byte = b;
            else if (header_pos < 4)
                seq_acc = {seq_acc[7:0], b};
            else if (header_pos < 8)
                stamp_acc = {stamp_acc[23:0], b};
            else if (header_pos < FIXED_HEADER_LEN)
                ssrc_acc = {ssrc_acc[23:0], b};
            count = header_pos + 1'b1;
            hdr_len = FIXED_HEADER_LEN + {1'b0, vcc_byte[3:0], 2'b00};
            if (count < FIXED_HEADER_LEN)
            begin
                if (last)
                begin
                    r.kind = KIND_ERROR;
                    r.error_code = ERR_SHORT_FIXED;
                    r.packet_end = 1'b1;
                    queue_result(r);
                    clear_packet();
                end
                else
                    header_pos = count;
                return;
            end
            if (count == FIXED_HEADER_LEN && vcc_byte[7:6] != RTP_VERSION)
            begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_BAD_VERSION;
                r.packet_end = last;
                queue_result(r);
                if (last)
                    clear_packet();
                else
                    dropping = 1'b1;
                return;
            end
            if (count >= hdr_len)
            begin
                r.kind = KIND_HEADER;
                r.marker = mpt_byte[7];
                r.payload_type = mpt_byte[6:0];
                r.sequence_res = seq_acc;
                r.stamp = stamp_acc;
                r.source_id = ssrc_acc;
                r.csrc_count = vcc_byte[3:0];
                r.packet_end = last;
                queue_result(r);
                if (last)
                    clear_packet();
                else
                    in_payload = 1'b1;
                return;
            end
            if (last)
            begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_SHORT_CSRC;
                r.packet_end = 1'b1;
                queue_result(r);
                clear_packet();
            end
            else
                header_pos = count;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(rhp_result_t got);
            rhp_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result of kind %0d with no expectation pending", got.kind);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("marker", 32'(want.marker), 32'(got.marker));
            compare_field("payload_type", 32'(want.payload_type), 32'(got.payload_type));
            compare_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
            compare_field("stamp", want.stamp, got.stamp);
            compare_field("source_id", want.source_id, got.source_id);
            compare_field("csrc_count", 32'(want.csrc_count), 32'(got.csrc_count));
            compare_field("payload_data", 32'(want.payload_data), 32'(got.payload_data));
            compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
            compare_field("packet_end", 32'(want.packet_end), 32'(got.packet_end));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_res;
    logic [31:0] stamp;
    logic [31:0] source_id;
    logic [3:0]  csrc_count;
    logic [7:0]  payload_data;
    logic [1:0]  error_code;
    logic        packet_end;

    rtp_result_board sb = new();
    logic [7:0]      packet_bytes[$];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              idle_cycles;

    rtp_header_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .marker       (marker),
        .payload_type (payload_type),
        .sequence_res (sequence_res),
        .stamp        (stamp),
        .source_id    (source_id),
        .csrc_count   (csrc_count),
        .payload_data (payload_data),
        .error_code   (error_code),
        .packet_end   (packet_end)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({kind, marker, payload_type, sequence_res, stamp, source_id,
                             csrc_count, payload_data, error_code, packet_end});
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic void add_byte(logic [7:0] b);
        packet_bytes.insert(packet_bytes.size(), b);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < packet_bytes.size(); i++)
            send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int byte_goal);
        int          pick;
        int          cc;
        int          len;
        logic [1:0]  ver;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sb.parsed_bytes < byte_goal)
        begin
            pick = $urandom_range(99);
            packet_bytes.delete();
            if (pick < 65)
            begin
                cc = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
                add_byte({RTP_VERSION, 2'($urandom_range(3)), 4'(cc)});
                repeat (11 + 4 * cc + $urandom_range(24))
                    add_byte(8'($urandom));
            end
            else if (pick < 80)
            begin
                cc = $urandom_range(15);
                len = $urandom_range(1, 11 + 4 * cc);
                add_byte({RTP_VERSION, 2'($urandom_range(3)), 4'(cc)});
                repeat (len - 1)
                    add_byte(8'($urandom));
            end
            else if (pick < 90)
            begin
                ver = 2'($urandom_range(2));
                if (ver == RTP_VERSION)
                    ver = 2'd3;
                add_byte({ver, 6'($urandom)});
                repeat (11 + ($urandom_range(1) ? 0 : $urandom_range(10)))
                    add_byte(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 40))
                    add_byte(8'($urandom));
            end
            send_packet();
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        packet_bytes = {8'hFF};
        send_packet();
        packet_bytes.delete();
        add_byte({RTP_VERSION, 6'h00});
        repeat (11)
            add_byte(8'hFF);
        send_packet();
        packet_bytes.delete();
        repeat (12)
            add_byte(8'h00);
        packet_bytes[0] = 8'h4F;
        send_packet();
        wait_for_results();

        run_phase(6, 52, DIRECTED_BYTES + RANDOM_BYTES / 3);
        run_phase(52, 6, DIRECTED_BYTES + 2 * RANDOM_BYTES / 3);
        run_phase(0, 0, DIRECTED_BYTES + RANDOM_BYTES);

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/rhp_pkg.sv
hdl/rhp_parser.sv
hdl/rhp_skid.sv
hdl/rtp_header_parser_top.sv
tb/rtp_header_parser_top_tb.sv
